FILE: rtl/humidity_temp_frame_decoder_top_defines.svh
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_top_defines
// Assertion macros shared by the frame decoder modules. The enclosing
// module must provide clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_TEMP_FRAME_DECODER_TOP_DEFINES_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define HTFD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define HTFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/htfd_pkg.sv
// ----------------------------------------------------------------------------
// htfd_pkg
// Types, constants and helper functions of the humidity / temperature
// frame decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

	// input item: one byte of the six-byte readout frame
	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} in_item_t;

	// result item: produced after the humidity crc byte
	typedef struct packed {
		logic signed [14:0] temperature_centi;
		logic [13:0]        humidity_centi;
		logic               temp_crc_ok;
		logic               hum_crc_ok;
	} out_item_t;

	// byte position within the frame
	typedef enum logic [2:0] {
		POS_T_MSB = 3'd0,
		POS_T_LSB = 3'd1,
		POS_T_CRC = 3'd2,
		POS_H_MSB = 3'd3,
		POS_H_LSB = 3'd4,
		POS_H_CRC = 3'd5
	} pos_t;

	localparam logic [7:0]  CRC_POLY    = 8'h31;
	localparam logic [7:0]  CRC_INIT    = 8'hFF;
	localparam int          PROD_W      = 31;
	localparam logic [14:0] TEMP_SPAN   = 15'd17500;
	localparam logic [14:0] HUM_SPAN    = 15'd10000;
	localparam logic [14:0] TEMP_OFFSET = 15'd4500;
	localparam logic [16:0] FULL_SCALE  = 17'd65535;

	// crc-8, msb first, one byte folded in
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	// floor(x / 65535) for x below 32768*65535: x>>16 plus one correction step
	function automatic logic [14:0] div_full_scale(input logic [PROD_W-1:0] x);
		logic [14:0] q0;
		logic [16:0] rem;
		q0  = x[PROD_W-1:16];
		rem = {1'b0, x[15:0]} + {2'b00, q0};
		if (rem >= FULL_SCALE) begin
			return q0 + 15'd1;
		end
		return q0;
	endfunction

endpackage

FILE: rtl/humidity_temp_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_top
// Decodes six-byte humidity / temperature readout frames with crc check.
// ----------------------------------------------------------------------------
// Usage:
//   src channel takes one frame byte per transfer (data_byte, frame_start).
//   Bytes come in order temperature msb, lsb, crc, humidity msb, lsb, crc;
//   frame_start restarts the frame at the temperature msb.
//   dst channel gives one result per frame, after the humidity crc byte:
//   last good temperature and humidity plus both crc flags.
// Path: a byte is first held in the input register; when the closing byte
//   leaves it, the result is loaded into the result register and offered
//   on dst from there, where it waits until it is taken.
// Throughput: one byte per cycle unless stalled; set by the single input
//   register feeding the crc/conversion logic and one-entry result register.
// Reset: position and readings clear, crc loads CRC_INIT, no result pending.
// Stall: a result waiting on dst_stall holds; the staged byte still moves
//   unless it would produce another result, then src_stall rises until the
//   result register is freed.
// ----------------------------------------------------------------------------
`include "humidity_temp_frame_decoder_top_defines.svh"

module humidity_temp_frame_decoder_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_stall,
	input  htfd_pkg::in_item_t  src_item,
	output logic                dst_valid,
	input  logic                dst_stall,
	output htfd_pkg::out_item_t dst_item
);
	import htfd_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      s1_fire;
	logic      produces;
	out_item_t result;
	logic      dst_valid_q;
	out_item_t dst_item_q;

	// staged byte moves on unless its result cannot be stored
	always_comb begin
		s1_fire   = valid_s1 && (!produces || !dst_valid_q || !dst_stall);
		src_stall = valid_s1 && !s1_fire;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!src_stall) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			item_s1 <= src_item;
		end
	end

	htfd_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_s1),
		.fire     (s1_fire),
		.produces (produces),
		.result   (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid_q <= 1'b0;
		end else if (s1_fire && produces) begin
			dst_valid_q <= 1'b1;
		end else if (!dst_stall) begin
			dst_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && produces) begin
			dst_item_q <= result;
		end
	end

	assign dst_valid = dst_valid_q;
	assign dst_item  = dst_item_q;

	`HTFD_ASSERT_SAME(a_no_overwrite, s1_fire && produces && dst_valid_q, !dst_stall, "pending result overwritten")
	`HTFD_ASSERT_NEXT(a_result_offered, s1_fire && produces, dst_valid_q, "result not offered after frame end")
	`HTFD_ASSERT_SAME(a_stall_cause, src_stall, dst_valid_q && dst_stall && produces, "input stalled without a blocked result")

endmodule

FILE: rtl/htfd_decode.sv
// ----------------------------------------------------------------------------
// htfd_decode
// Frame position tracking, crc check, fixed-point conversion and the last
// good readings. Updates when the top level consumes the staged byte.
// ----------------------------------------------------------------------------
`include "humidity_temp_frame_decoder_top_defines.svh"

module htfd_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  htfd_pkg::in_item_t  item,
	input  logic                fire,
	output logic                produces,
	output htfd_pkg::out_item_t result
);
	import htfd_pkg::*;

	pos_t               pos_q;
	pos_t               pos_eff;
	pos_t               pos_next;
	logic [7:0]         crc_q;
	logic [7:0]         raw_hi_q;
	logic [PROD_W-1:0]  prod_q;
	logic               temp_ok_q;
	logic [14:0]        last_temp_q;
	logic [13:0]        last_hum_q;
	logic [7:0]         crc_next;
	logic [15:0]        word;
	logic [14:0]        scale;
	logic [PROD_W-1:0]  prod;
	logic               crc_match;
	logic [14:0]        quot;
	logic [14:0]        temp_new;

	// effective position: frame_start restarts the frame
	always_comb begin
		pos_eff = pos_q;
		if (item.frame_start) begin
			pos_eff = POS_T_MSB;
		end
		produces = (pos_eff == POS_H_CRC);
	end

	// next position, wrapping after the humidity crc byte
	always_comb begin
		case (pos_eff)
			POS_T_MSB: pos_next = POS_T_LSB;
			POS_T_LSB: pos_next = POS_T_CRC;
			POS_T_CRC: pos_next = POS_H_MSB;
			POS_H_MSB: pos_next = POS_H_LSB;
			POS_H_LSB: pos_next = POS_H_CRC;
			default:   pos_next = POS_T_MSB;
		endcase
	end

	// crc update and scaled product of the completed word
	always_comb begin
		if (pos_eff == POS_T_MSB || pos_eff == POS_H_MSB) begin
			crc_next = crc8_byte(CRC_INIT, item.data_byte);
		end else begin
			crc_next = crc8_byte(crc_q, item.data_byte);
		end
		word  = {raw_hi_q, item.data_byte};
		scale = (pos_eff == POS_T_LSB) ? TEMP_SPAN : HUM_SPAN;
		prod  = {15'd0, word} * {16'd0, scale};
	end

	// crc check and conversion of the stored product
	always_comb begin
		crc_match = (item.data_byte == crc_q);
		quot      = div_full_scale(prod_q);
		temp_new  = quot - TEMP_OFFSET;
	end

	// result seen at the humidity crc byte
	always_comb begin
		result.temperature_centi = $signed(last_temp_q);
		result.humidity_centi    = crc_match ? quot[13:0] : last_hum_q;
		result.temp_crc_ok       = temp_ok_q;
		result.hum_crc_ok        = crc_match;
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_T_MSB;
			crc_q       <= CRC_INIT;
			raw_hi_q    <= 8'd0;
			prod_q      <= '0;
			temp_ok_q   <= 1'b0;
			last_temp_q <= 15'd0;
			last_hum_q  <= 14'd0;
		end else if (fire) begin
			pos_q <= pos_next;
			case (pos_eff)
				POS_T_MSB, POS_H_MSB: begin
					crc_q    <= crc_next;
					raw_hi_q <= item.data_byte;
				end
				POS_T_LSB, POS_H_LSB: begin
					crc_q  <= crc_next;
					prod_q <= prod;
				end
				POS_T_CRC: begin
					crc_q     <= CRC_INIT;
					temp_ok_q <= crc_match;
					if (crc_match) begin
						last_temp_q <= temp_new;
					end
				end
				POS_H_CRC: begin
					crc_q <= CRC_INIT;
					if (crc_match) begin
						last_hum_q <= quot[13:0];
					end
				end
				default: begin
					crc_q <= CRC_INIT;
				end
			endcase
		end
	end

	`HTFD_ASSERT_NEXT(a_wrap_after_result, fire && produces, pos_q == POS_T_MSB, "position did not wrap after result")
	`HTFD_ASSERT_NEXT(a_restart_position, fire && item.frame_start, pos_q == POS_T_LSB, "frame start did not restart position")
	`HTFD_ASSERT_NEXT(a_crc_reload, fire && !item.frame_start && pos_q == POS_T_CRC, crc_q == CRC_INIT, "crc not reloaded after temperature word")

endmodule
